// ----- src/dpt_pkg.sv -----
package dpt_pkg;

    localparam int NodeCount = 64;
    localparam int IdW       = 6;
    localparam int ValW      = 16;
    localparam int FracBits  = 16;
    localparam logic [FracBits:0] OneFx = {1'b1, {FracBits{1'b0}}};

    typedef enum logic [2:0] {
        K_ENCOUNTER = 3'd0,
        K_TRANS     = 3'd1,
        K_SINK      = 3'd2,
        K_AGE       = 3'd3,
        K_QUERY     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_SELF   = 3'd0,
        CFG_SINK   = 3'd1,
        CFG_INIT   = 3'd2,
        CFG_DECAY  = 3'd3,
        CFG_TRANS  = 3'd4,
        CFG_STRICT = 3'd5
    } t_cfg_idx;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]      op;
        logic [IdW-1:0]  idx;
        logic [ValW-1:0] peer;
        logic [7:0]      slots;
        logic            coin;
        logic            nop;   // produces an all-zero result
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL1,
        S_MUL2,
        S_UPD,
        S_WR,
        S_FPOW,
        S_AGE_RD,
        S_AGE_WR,
        S_OUT
    } t_state;

    function automatic logic [ValW-1:0] fx_mul16(input logic [ValW-1:0] a,
                                                 input logic [ValW-1:0] b);
        logic [2*ValW-1:0] p;
        p = a * b;
        return p[2*ValW-1:FracBits];
    endfunction

endpackage

// ----- src/dpt_front.sv -----
module dpt_front (
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_kind,
    input  logic [5:0]              i_node,
    input  logic [15:0]             i_peer_pred,
    input  logic [7:0]              i_elapsed_slots,
    input  logic                    i_coin,
    input  logic [5:0]              i_self_id,
    input  logic                    i_q_full,
    output logic                    o_push,
    output dpt_pkg::t_cmd           o_cmd
);
    // classify: pass the item's node on as the table index and decide whether it is a no-op
    always_comb begin
        o_cmd.op    = i_kind;
        o_cmd.peer  = i_peer_pred;
        o_cmd.slots = i_elapsed_slots;
        o_cmd.coin  = i_coin;
        o_cmd.idx   = i_node;
        o_cmd.nop   = 1'b0;
        case (i_kind)
            dpt_pkg::K_ENCOUNTER: o_cmd.nop = 1'b0;
            dpt_pkg::K_TRANS:     o_cmd.nop = (i_node == i_self_id);
            dpt_pkg::K_SINK:      o_cmd.nop = 1'b0;
            dpt_pkg::K_AGE:       o_cmd.nop = 1'b0;
            dpt_pkg::K_QUERY:     o_cmd.nop = 1'b0;
            default:              o_cmd.nop = 1'b1;
        endcase
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid & ~i_q_full;
endmodule

// ----- src/dpt_queue.sv -----
module dpt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output dpt_pkg::t_cmd o_cmd
);
    dpt_pkg::t_cmd r_buf [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ----- src/dpt_back.sv -----
module dpt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  dpt_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [5:0]    i_sink_id,
    input  logic [15:0]   i_init_pred,
    input  logic [15:0]   i_decay_ratio,
    input  logic [15:0]   i_trans_ratio,
    input  logic          i_strict_ties,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [15:0]   o_pred_value,
    output logic          o_forward,
    output logic          o_tie
);
    localparam int IdW = dpt_pkg::IdW;

    logic [15:0]        r_mem [dpt_pkg::NodeCount];
    logic [dpt_pkg::NodeCount-1:0] r_vld, n_vld;
    logic [15:0]        r_rdata;
    logic [15:0]        r_tw, n_tw;

    dpt_pkg::t_state    r_state, n_state;
    dpt_pkg::t_cmd      r_cmd, n_cmd;
    logic [15:0]        r_p, n_p;
    logic [15:0]        r_x, n_x;
    logic [15:0]        r_f, n_f;
    logic [7:0]         r_cnt, n_cnt;
    logic [IdW:0]       r_ai, n_ai;
    logic [15:0]        r_val, n_val;
    logic               r_fwd, n_fwd, r_tie, n_tie, r_ov, n_ov;
    logic               r_fone, n_fone;   // aging factor still equals one

    logic [IdW-1:0]     rd_addr;
    logic               we;
    logic [IdW-1:0]     wa;
    logic [15:0]        wd;
    logic [16:0]        comp;
    logic [32:0]        prod;
    logic [16:0]        sum;
    logic [31:0]        fmul;
    logic [15:0]        upd;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // raise toward one: P + (ONE-P)*x, saturated; also the aging product entry*f
    always_comb begin
        comp = dpt_pkg::OneFx - {1'b0, r_p};
        prod = comp * r_x;
        sum  = {1'b0, r_p} + prod[32:16];
        upd  = sum[16] ? 16'hFFFF : sum[15:0];
        fmul = (r_fone ? {16'd0, r_rdata} << 16 : r_rdata * r_f);
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_p     = r_p;
        n_x     = r_x;
        n_f     = r_f;
        n_cnt   = r_cnt;
        n_ai    = r_ai;
        n_val   = r_val;
        n_fwd   = r_fwd;
        n_tie   = r_tie;
        n_ov    = r_ov;
        n_vld   = r_vld;
        n_tw    = r_tw;
        n_fone  = r_fone;
        o_pop   = 1'b0;
        we      = 1'b0;
        wa      = r_cmd.idx;
        wd      = upd;
        rd_addr = r_cmd.idx;
        case (r_state)
            dpt_pkg::S_IDLE: begin
                rd_addr = i_cmd.idx;
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_val = '0;
                    n_fwd = 1'b0;
                    n_tie = 1'b0;
                    if (i_cmd.op == dpt_pkg::K_SINK || i_cmd.op == dpt_pkg::K_QUERY) begin
                        n_cmd.idx = i_sink_id;
                        rd_addr   = i_sink_id;
                    end
                    if (i_cmd.nop) begin
                        n_state = dpt_pkg::S_OUT;
                    end else if (i_cmd.op == dpt_pkg::K_AGE) begin
                        n_f     = '0;
                        n_fone  = 1'b1;
                        n_cnt   = i_cmd.slots;
                        n_state = dpt_pkg::S_FPOW;
                    end else begin
                        n_state = dpt_pkg::S_RD;
                    end
                end
            end
            dpt_pkg::S_RD: begin
                case (r_cmd.op)
                    dpt_pkg::K_ENCOUNTER: begin
                        n_p = r_vld[r_cmd.idx] ? r_rdata : i_init_pred;
                        n_x = i_init_pred;
                        n_state = dpt_pkg::S_UPD;
                    end
                    dpt_pkg::K_SINK: begin
                        n_p = r_vld[r_cmd.idx] ? r_rdata : 16'd0;
                        n_x = i_init_pred;
                        n_state = dpt_pkg::S_UPD;
                    end
                    dpt_pkg::K_TRANS: begin
                        n_p = r_vld[r_cmd.idx] ? r_rdata : i_init_pred;
                        n_state = dpt_pkg::S_MUL1;
                    end
                    default: begin
                        n_p   = r_vld[r_cmd.idx] ? r_rdata : 16'd0;
                        n_val = n_p;
                        if (r_cmd.peer == n_p) begin
                            n_tie = 1'b1;
                            n_fwd = i_strict_ties ? 1'b0 : r_cmd.coin;
                        end else begin
                            n_fwd = (r_cmd.peer > n_p);
                        end
                        n_state = dpt_pkg::S_OUT;
                    end
                endcase
            end
            dpt_pkg::S_MUL1: begin
                n_x = dpt_pkg::fx_mul16(r_tw, r_cmd.peer);
                n_state = dpt_pkg::S_MUL2;
            end
            dpt_pkg::S_MUL2: begin
                n_x = dpt_pkg::fx_mul16(r_x, i_trans_ratio);
                n_state = dpt_pkg::S_UPD;
            end
            dpt_pkg::S_UPD: begin
                n_p = upd;
                n_state = dpt_pkg::S_WR;
            end
            dpt_pkg::S_WR: begin
                we = 1'b1;
                wd = r_p;
                n_vld[r_cmd.idx] = 1'b1;
                n_val = r_p;
                if (r_cmd.op == dpt_pkg::K_ENCOUNTER) begin
                    n_tw = r_p;
                end
                n_state = dpt_pkg::S_OUT;
            end
            dpt_pkg::S_FPOW: begin
                // one multiply per slot: f = f * gamma
                if (r_cnt == 8'd0) begin
                    n_ai    = '0;
                    rd_addr = '0;
                    n_state = dpt_pkg::S_AGE_RD;
                end else begin
                    n_f    = r_fone ? i_decay_ratio : dpt_pkg::fx_mul16(r_f, i_decay_ratio);
                    n_fone = 1'b0;
                    n_cnt  = r_cnt - 8'd1;
                end
            end
            dpt_pkg::S_AGE_RD: begin
                rd_addr = r_ai[IdW-1:0];
                n_state = dpt_pkg::S_AGE_WR;
            end
            dpt_pkg::S_AGE_WR: begin
                wa = r_ai[IdW-1:0];
                wd = fmul[31:16];
                we = r_vld[r_ai[IdW-1:0]];
                n_ai = r_ai + 1'b1;
                rd_addr = n_ai[IdW-1:0];
                if (r_ai == (IdW+1)'(dpt_pkg::NodeCount - 1)) begin
                    n_state = dpt_pkg::S_OUT;
                end else begin
                    n_state = dpt_pkg::S_AGE_RD;
                end
            end
            dpt_pkg::S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_state = dpt_pkg::S_IDLE;
                end
            end
            default: n_state = dpt_pkg::S_IDLE;
        endcase
        if (r_ov && !i_stall && !(r_state == dpt_pkg::S_OUT)) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpt_pkg::S_IDLE;
            r_vld   <= '0;
            r_tw    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_tw    <= n_tw;
            r_ov    <= n_ov;
        end
    end

    // output register is loaded only when leaving S_OUT
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_p    <= n_p;
        r_x    <= n_x;
        r_f    <= n_f;
        r_fone <= n_fone;
        r_cnt  <= n_cnt;
        r_ai   <= n_ai;
        r_val  <= (r_state == dpt_pkg::S_OUT) ? r_val : n_val;
        r_fwd  <= (r_state == dpt_pkg::S_OUT) ? r_fwd : n_fwd;
        r_tie  <= (r_state == dpt_pkg::S_OUT) ? r_tie : n_tie;
        if (r_state == dpt_pkg::S_OUT && (!r_ov || !i_stall)) begin
            o_pred_value <= r_val;
            o_forward    <= r_fwd;
            o_tie        <= r_tie;
        end
    end

    assign o_valid = r_ov;
endmodule

// ----- src/delivery_predictability_table_core.sv -----
// Delivery predictability table core (UQ0.16 fixed point).
// Input channel: i_valid/o_stall with kind, node, peer_pred, elapsed_slots
// and coin; a transfer happens when i_valid is high and o_stall is low.
// Output channel: o_valid/i_stall with pred_value, forward and tie; one
// result per input item, in order.
// Config channel: i_cfg_valid/o_cfg_ready with register index and data;
// write only while the block is idle.
// A front stage classifies items into a two-entry queue; the back sequencer
// executes them against a 64-entry table RAM (one read and one write port).
// Items run one at a time. Encounter/sink: read, update, write, output;
// transitive adds two multiplies after the read; query: read, output;
// no-op: output. Aging raises gamma to the power elapsed_slots, one
// multiply per slot, then reads every entry and rewrites the valid ones.
// Reset clears all valid bits (invalid entries read as their default), the
// transitive weight and the registers to their reset values.
// When the receiver stalls, the result waits in the output register; the
// queue keeps accepting until full, then o_stall rises.
module delivery_predictability_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [5:0]  i_node,
    input  logic [15:0] i_peer_pred,
    input  logic [7:0]  i_elapsed_slots,
    input  logic        i_coin,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pred_value,
    output logic        o_forward,
    output logic        o_tie,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [5:0]    r_self_id, r_sink_id;
    logic [15:0]   r_init, r_decay, r_trans;
    logic          r_strict;

    logic          q_push, q_full, q_pop, q_empty;
    dpt_pkg::t_cmd f_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id <= '0;
            r_sink_id <= '0;
            r_init    <= 16'd49152;
            r_decay   <= 16'd64880;
            r_trans   <= 16'd16384;
            r_strict  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dpt_pkg::CFG_SELF:   r_self_id <= i_cfg_data[5:0];
                dpt_pkg::CFG_SINK:   r_sink_id <= i_cfg_data[5:0];
                dpt_pkg::CFG_INIT:   r_init    <= i_cfg_data;
                dpt_pkg::CFG_DECAY:  r_decay   <= i_cfg_data;
                dpt_pkg::CFG_TRANS:  r_trans   <= i_cfg_data;
                dpt_pkg::CFG_STRICT: r_strict  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dpt_front u_front (
        .i_valid(i_valid), .o_stall(o_stall),
        .i_kind(i_kind), .i_node(i_node), .i_peer_pred(i_peer_pred),
        .i_elapsed_slots(i_elapsed_slots), .i_coin(i_coin),
        .i_self_id(r_self_id), .i_q_full(q_full),
        .o_push(q_push), .o_cmd(f_cmd)
    );

    dpt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_cmd(f_cmd), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    dpt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_cmd(q_cmd), .o_pop(q_pop),
        .i_sink_id(r_sink_id), .i_init_pred(r_init), .i_decay_ratio(r_decay),
        .i_trans_ratio(r_trans), .i_strict_ties(r_strict),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pred_value(o_pred_value), .o_forward(o_forward), .o_tie(o_tie)
    );
endmodule

// ----- tb/delivery_predictability_table_core_tb.sv -----
module delivery_predictability_table_core_tb;

    // ------------------------------------------------------------------
    // Clock, reset, DUT hookup
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_kind = '0;
    logic [5:0]  i_node = '0;
    logic [15:0] i_peer_pred = '0;
    logic [7:0]  i_elapsed_slots = '0;
    logic        i_coin = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_pred_value;
    logic        o_forward;
    logic        o_tie;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    delivery_predictability_table_core dut (.*);

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the table and registers
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [15:0] value;
        logic        fwd;
        logic        tie;
    } t_result;

    logic [5:0]  self_node, sink_node;
    logic [15:0] init_p, gamma, beta;
    logic        strict;
    logic [15:0] table_p [dpt_pkg::NodeCount];
    logic        table_v [dpt_pkg::NodeCount];
    logic [15:0] weight;

    t_result expected_results [$];
    int          errors = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    bit          quiet = 1'b0;      // last phase: no random idling
    bit          hold_sink = 1'b0;  // long receiver hold-off requested

    function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
        return (a * b) >> dpt_pkg::FracBits;
    endfunction

    function automatic logic [15:0] sat(logic [63:0] v);
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // P + (1-P)*x, complement clamps to zero once P reaches one
    function automatic logic [15:0] raise_p(logic [63:0] p, logic [63:0] x);
        logic [63:0] comp;
        comp = (p >= 64'd65536) ? 64'd0 : 64'd65536 - p;
        return sat(p + fmul(comp, x));
    endfunction

    function automatic t_result predict_table(logic [2:0] kind, logic [5:0] node,
                                              logic [15:0] peer, logic [7:0] slots,
                                              logic coin);
        t_result     r;
        logic [63:0] p, x, f;
        r = '0;
        case (kind)
            dpt_pkg::K_ENCOUNTER: begin
                p = table_v[node] ? table_p[node] : init_p;
                table_p[node] = raise_p(p, init_p);
                table_v[node] = 1'b1;
                weight = table_p[node];
                r.value = table_p[node];
            end
            dpt_pkg::K_TRANS: begin
                // own id is skipped entirely
                if (node != self_node) begin
                    p = table_v[node] ? table_p[node] : init_p;
                    x = fmul(fmul(weight, peer), beta);
                    table_p[node] = raise_p(p, x);
                    table_v[node] = 1'b1;
                    r.value = table_p[node];
                end
            end
            dpt_pkg::K_SINK: begin
                p = table_v[sink_node] ? table_p[sink_node] : 0;
                table_p[sink_node] = raise_p(p, init_p);
                table_v[sink_node] = 1'b1;
                r.value = table_p[sink_node];
            end
            dpt_pkg::K_AGE: begin
                f = 64'd65536;
                for (int i = 0; i < slots; i++) f = fmul(f, gamma);
                for (int i = 0; i < dpt_pkg::NodeCount; i++)
                    if (table_v[i]) table_p[i] = sat(fmul(table_p[i], f));
            end
            dpt_pkg::K_QUERY: begin
                p = table_v[sink_node] ? table_p[sink_node] : 0;
                r.value = p[15:0];
                if (peer == p) begin
                    r.tie = 1'b1;
                    r.fwd = strict ? 1'b0 : coin;
                end else begin
                    r.fwd = (peer > p);
                end
            end
            default: ;  // unknown kinds give an all-zero result
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)",
                 what, got, want, results_seen);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: compares each output transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", o_pred_value, 0);
            end else begin
                t_result e;
                e = expected_results.pop_front();
                if (o_pred_value !== e.value) report("pred_value", o_pred_value, e.value);
                if (o_forward !== e.fwd) report("forward", o_forward, e.fwd);
                if (o_tie !== e.tie) report("tie", o_tie, e.tie);
            end
            results_seen++;
        end
    end

    // Receiver stall: random bursts, or a long hold-off when asked
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                i_stall <= 1'b1;
                for (int c = 0; c < 60; c++) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_sink = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                i_stall <= 1'b1;
                for (int c = 0; c < n; c++) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(logic [2:0] kind, logic [5:0] node, logic [15:0] peer,
                             logic [7:0] slots, logic coin);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_node <= node;
        i_peer_pred <= peer;
        i_elapsed_slots <= slots;
        i_coin <= coin;
        do @(posedge i_clk); while (o_stall);
        expected_results.insert(expected_results.size(),
                                predict_table(kind, node, peer, slots, coin));
        items_sent++;
    endtask

    // Wait for the block to drain, then let aging finish before config writes
    task automatic wait_idle();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_reg(dpt_pkg::t_cfg_idx idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            dpt_pkg::CFG_SELF:   self_node = data[5:0];
            dpt_pkg::CFG_SINK:   sink_node = data[5:0];
            dpt_pkg::CFG_INIT:   init_p = data;
            dpt_pkg::CFG_DECAY:  gamma = data;
            dpt_pkg::CFG_TRANS:  beta = data;
            dpt_pkg::CFG_STRICT: strict = data[0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [5:0] s, logic [5:0] k, logic [15:0] ip,
                           logic [15:0] g, logic [15:0] b, logic st);
        wait_idle();
        write_reg(dpt_pkg::CFG_SELF, s);
        write_reg(dpt_pkg::CFG_SINK, k);
        write_reg(dpt_pkg::CFG_INIT, ip);
        write_reg(dpt_pkg::CFG_DECAY, g);
        write_reg(dpt_pkg::CFG_TRANS, b);
        write_reg(dpt_pkg::CFG_STRICT, st);
    endtask

    // Random item; mostly meaningful kinds, some unknown-kind noise.
    // Aging mostly uses few slots to keep runtime down.
    task automatic random_item();
        logic [2:0] k;
        logic [7:0] sl;
        logic [15:0] pp;
        k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        sl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        pp = 16'($urandom);
        // queries: often hit the current sink value to provoke ties
        if (k == dpt_pkg::K_QUERY && $urandom_range(0, 2) == 0)
            pp = table_v[sink_node] ? table_p[sink_node] : 16'd0;
        send_item(k, 6'($urandom_range(0, 15)), pp, sl, 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_defaults();
        send_item(dpt_pkg::K_QUERY, 0, 16'd0, 0, 1);     // missing sink reads 0, strict tie
        send_item(dpt_pkg::K_TRANS, 5, 16'hFFFF, 0, 0);  // weight 0, missing entry reads init
        send_item(dpt_pkg::K_ENCOUNTER, 63, 0, 0, 0);
        send_item(dpt_pkg::K_ENCOUNTER, 63, 0, 0, 0);
        send_item(dpt_pkg::K_TRANS, 7, 16'hFFFF, 0, 0);
        send_item(dpt_pkg::K_TRANS, 0, 16'hFFFF, 0, 0);  // own id skipped
        send_item(dpt_pkg::K_SINK, 0, 0, 0, 0);
        send_item(dpt_pkg::K_QUERY, 0, 16'hFFFF, 0, 0);
        send_item(dpt_pkg::K_QUERY, 0, 16'd0, 0, 0);
        send_item(dpt_pkg::K_AGE, 0, 0, 8'd0, 0);
        send_item(dpt_pkg::K_AGE, 0, 0, 8'd255, 0);      // full decay sweep
        send_item(dpt_pkg::K_AGE, 0, 0, 8'd1, 0);
        send_item(3'd5, 6'h2A, 16'hAAAA, 8'hAA, 1);
        send_item(3'd6, 6'h15, 16'h5555, 8'h55, 0);
        send_item(3'd7, 6'h3F, 16'hFFFF, 8'hFF, 1);
    endtask

    task automatic test_extreme_config();
        // init and beta at their maximum (0xFFFF) drive entries to saturation
        set_all(6'd63, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(dpt_pkg::K_SINK, 0, 0, 0, 0);
        send_item(dpt_pkg::K_SINK, 0, 0, 0, 0);
        send_item(dpt_pkg::K_ENCOUNTER, 1, 0, 0, 0);
        send_item(dpt_pkg::K_TRANS, 2, 16'hFFFF, 0, 0);
        send_item(dpt_pkg::K_TRANS, 63, 16'hFFFF, 0, 0);
        send_item(dpt_pkg::K_QUERY, 0, table_p[63], 0, 1); // non-strict tie, coin 1
        send_item(dpt_pkg::K_QUERY, 0, table_p[63], 0, 0);
        send_item(dpt_pkg::K_AGE, 0, 0, 8'd3, 0);
        set_all(6'd0, 6'd1, 16'd0, 16'd0, 16'd0, 1'b1);
        send_item(dpt_pkg::K_ENCOUNTER, 9, 0, 0, 0);
        send_item(dpt_pkg::K_SINK, 0, 0, 0, 0);
        send_item(dpt_pkg::K_AGE, 0, 0, 8'd1, 0);
        send_item(dpt_pkg::K_QUERY, 0, 16'd0, 0, 1);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) random_item();
    endtask

    task automatic test_backpressure();
        // receiver holds off while we keep offering, so the block fills up
        hold_sink = 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(dpt_pkg::K_ENCOUNTER, 6'($urandom_range(0, 63)), 0, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        self_node = 0; sink_node = 0; init_p = 16'd49152;
        gamma = 16'd64880; beta = 16'd16384; strict = 1'b1; weight = 0;
        for (int i = 0; i < dpt_pkg::NodeCount; i++) begin
            table_p[i] = 0;
            table_v[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_extreme_config();
        set_all(6'd3, 6'd4, 16'd49152, 16'd64880, 16'd16384, 1'b0);
        test_random(200);
        test_backpressure();
        set_all(6'($urandom), 6'($urandom_range(0, 15)), 16'($urandom),
                16'($urandom), 16'($urandom), 1'b1);
        test_random(200);
        set_all(6'd10, 6'd2, 16'd32768, 16'd60000, 16'd65535, 1'b0);
        quiet = 1'b1;
        test_random(170);

        wait_idle();
        if (expected_results.size() != 0) begin
            report("missing results", expected_results.size(), 0);
        end
        $display("Covered %0d items and %0d results over several register settings,",
                 items_sent, results_seen);
        $display("with random idling, a long receiver hold-off and input backpressure.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
